// ===== hdl/qcmv_pkg.sv =====
// ----------------------------------------------------------------------------
// qcmv_pkg
// Shared types and constants of the quasi-cyclic GF(2) matrix-vector unit.
// ----------------------------------------------------------------------------
`default_nettype none

package qcmv_pkg;

  localparam int BLK_W   = 64;  // widest lifted block
  localparam int ROW_W   = 6;   // row index field
  localparam int COL_W   = 8;   // column index field
  localparam int SHIFT_W = 16;  // shift field
  localparam int Z_W     = 7;   // lifting size register
  localparam int CU_W    = 8;   // columns-in-use register
  localparam int RSH_W   = 6;   // reduced shift, always below Z <= 64

  // Register map, selected by paddr[2].
  localparam logic REG_LIFTING = 1'b0;
  localparam logic REG_COLUMNS = 1'b1;

  typedef enum logic [1:0] {
    ACT_LOAD_X = 2'd0,
    ACT_LOAD_B = 2'd1,
    ACT_APPLY  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  // Settled configuration seen by the front and back parts.
  typedef struct packed {
    logic [Z_W-1:0]   z;
    logic [BLK_W-1:0] mask;
    logic [CU_W-1:0]  cols;
  } cfg_t;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    action_t            action;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [RSH_W-1:0]   shift;
    logic               in_store;
    logic               col_ok;
    logic [BLK_W-1:0]   data;
  } entry_t;

endpackage

`default_nettype wire

// ===== hdl/qcmv_ram.sv =====
// ----------------------------------------------------------------------------
// qcmv_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module qcmv_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/qcmv_queue.sv =====
// ----------------------------------------------------------------------------
// qcmv_queue
// Two-entry queue of classified items between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module qcmv_queue
  import qcmv_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire entry_t push_entry,
  output logic        full,
  input  wire logic   pop,
  output entry_t      head,
  output logic        empty
);

  entry_t     slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign head  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/qcmv_front.sv =====
// ----------------------------------------------------------------------------
// qcmv_front
// Takes input items, reduces the shift modulo Z and classifies the item.
// ----------------------------------------------------------------------------
`default_nettype none

module qcmv_front
  import qcmv_pkg::*;
#(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cfg_t               cfg,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_action,
  input  wire logic [ROW_W-1:0]   in_row_index,
  input  wire logic [COL_W-1:0]   in_column_index,
  input  wire logic [SHIFT_W-1:0] in_shift_amount,
  input  wire logic [BLK_W-1:0]   in_block_data,
  input  wire logic               q_full,
  output logic                    q_push,
  output entry_t                  q_entry
);

  action_t              act_r;
  logic [ROW_W-1:0]     row_r;
  logic [COL_W-1:0]     col_r;
  logic [SHIFT_W-1:0]   shift_r;
  logic [BLK_W-1:0]     data_r;
  logic [Z_W-1:0]       rem_r;
  logic                 hold_r;
  logic                 phase_r;
  logic                 accept;
  logic [Z_W-1:0]       rem_fin;

  // Eight restoring steps of remainder = (remainder * 256 + byte) mod z.
  function automatic logic [Z_W-1:0] mod_byte(input logic [Z_W-1:0] rem,
                                               input logic [7:0]     byte_in,
                                               input logic [Z_W-1:0] z);
    logic [Z_W:0]   t;
    logic [Z_W-1:0] r;
    r = rem;
    for (int i = 7; i >= 0; i--) begin
      t = {r, byte_in[i]};
      if (t >= {1'b0, z}) begin
        t = t - {1'b0, z};
      end
      r = t[Z_W-1:0];
    end
    return r;
  endfunction

  assign rem_fin = mod_byte(rem_r, shift_r[7:0], cfg.z);
  assign q_push  = hold_r && phase_r && !q_full;
  assign busy    = hold_r && !q_push;
  assign accept  = start && !busy;

  always_comb begin
    q_entry        = '0;
    q_entry.action = act_r;
    q_entry.row    = row_r;
    q_entry.col    = col_r;
    q_entry.shift  = rem_fin[RSH_W-1:0];
    q_entry.data   = data_r & cfg.mask;
    q_entry.col_ok = (col_r < cfg.cols) && ({1'b0, col_r} < 9'(MAX_COLS));
    unique case (act_r)
      ACT_LOAD_X:            q_entry.in_store = ({1'b0, col_r} < 9'(MAX_COLS));
      ACT_LOAD_B, ACT_APPLY: q_entry.in_store = ({3'b000, row_r} < 9'(MAX_ROWS));
      default:               q_entry.in_store = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r  <= 1'b0;
      phase_r <= 1'b0;
    end else if (accept) begin
      hold_r  <= 1'b1;
      phase_r <= 1'b0;
    end else begin
      if (q_push) begin
        hold_r <= 1'b0;
      end
      if (hold_r && !phase_r) begin
        phase_r <= 1'b1;
      end
    end
    if (accept) begin
      act_r   <= action_t'(in_action);
      row_r   <= in_row_index;
      col_r   <= in_column_index;
      shift_r <= in_shift_amount;
      data_r  <= in_block_data;
    end else if (hold_r && !phase_r) begin
      // The high byte is reduced first, the low byte on the pushing cycle.
      rem_r <= mod_byte('0, shift_r[15:8], cfg.z);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/qcmv_back.sv =====
// ----------------------------------------------------------------------------
// qcmv_back
// Executes classified items against the vector and accumulator stores.
// ----------------------------------------------------------------------------
`default_nettype none

module qcmv_back
  import qcmv_pkg::*;
#(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cfg_t              cfg,
  input  wire entry_t            q_head,
  input  wire logic              q_empty,
  output logic                   q_pop,
  output logic                   out_valid,
  output logic [BLK_W-1:0]       out_block_value,
  output logic                   out_row_stopped
);

  localparam int COL_AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t             state_r;
  entry_t             cur_r;
  logic [ROW_W-1:0]   cur_row_r;
  logic [ROW_W-1:0]   cur_row_nxt;
  logic               stop_r;
  logic               stop_nxt;
  logic               stop_eff;
  logic [BLK_W-1:0]   vec_rd;
  logic [BLK_W-1:0]   acc_rd;
  logic [BLK_W-1:0]   vec_masked;
  logic [BLK_W-1:0]   rotated;
  logic [BLK_W-1:0]   value;
  logic               stopped;
  logic               vec_we;
  logic               acc_we;
  logic [BLK_W-1:0]   acc_wdata;
  logic [Z_W-1:0]     back_shift;
  logic [8:0]         head_row_ext;
  logic [8:0]         cur_row_ext;

  assign q_pop        = (state_r == ST_IDLE) && !q_empty;
  assign head_row_ext = {3'b000, q_head.row};
  assign cur_row_ext  = {3'b000, cur_r.row};

  qcmv_ram #(.WIDTH(BLK_W), .DEPTH(MAX_COLS)) u_vec_ram (
    .clk   (clk),
    .we    (vec_we),
    .waddr (cur_r.col[COL_AW-1:0]),
    .wdata (cur_r.data),
    .raddr (q_head.col[COL_AW-1:0]),
    .rdata (vec_rd)
  );

  qcmv_ram #(.WIDTH(BLK_W), .DEPTH(MAX_ROWS)) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (cur_row_ext[ROW_AW-1:0]),
    .wdata (acc_wdata),
    .raddr (head_row_ext[ROW_AW-1:0]),
    .rdata (acc_rd)
  );

  // Right rotation within Z bits; a zero shift leaves the block as it is,
  // since the left part then moves entirely above the mask.
  assign back_shift = cfg.z - {1'b0, cur_r.shift};
  assign vec_masked = vec_rd & cfg.mask;
  assign rotated    = ((vec_masked >> cur_r.shift) | (vec_masked << back_shift)) & cfg.mask;

  // An apply to a different row starts that row afresh.
  assign stop_eff = (cur_r.row == cur_row_r) ? stop_r : 1'b0;

  always_comb begin
    vec_we      = 1'b0;
    acc_we      = 1'b0;
    acc_wdata   = cur_r.data;
    value       = '0;
    stopped     = 1'b0;
    cur_row_nxt = cur_row_r;
    stop_nxt    = stop_r;
    if (state_r == ST_EXEC) begin
      unique case (cur_r.action)
        ACT_LOAD_X: begin
          if (cur_r.in_store) begin
            vec_we = 1'b1;
            value  = cur_r.data;
          end
        end
        ACT_LOAD_B: begin
          if (cur_r.in_store) begin
            acc_we = 1'b1;
            value  = cur_r.data;
          end
        end
        ACT_APPLY: begin
          cur_row_nxt = cur_r.row;
          stop_nxt    = stop_eff;
          priority if (!cur_r.in_store) begin
            stopped = 1'b1;
          end else if (stop_eff) begin
            value   = acc_rd;
            stopped = 1'b1;
          end else if (!cur_r.col_ok) begin
            stop_nxt = 1'b1;
            value    = acc_rd;
            stopped  = 1'b1;
          end else begin
            acc_we    = 1'b1;
            acc_wdata = (acc_rd ^ rotated) & cfg.mask;
            value     = acc_wdata;
          end
        end
        default: begin
          value = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_valid <= 1'b0;
      cur_row_r <= '0;
      stop_r    <= 1'b0;
    end else begin
      out_valid <= (state_r == ST_EXEC);
      cur_row_r <= cur_row_nxt;
      stop_r    <= stop_nxt;
      unique case (state_r)
        ST_IDLE: begin
          if (q_pop) begin
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
    if (q_pop) begin
      cur_r <= q_head;
    end
    if (state_r == ST_EXEC) begin
      out_block_value <= value;
      out_row_stopped <= stopped;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/quasi_cyclic_gf2_matrix_vector_multiply.sv =====
// ----------------------------------------------------------------------------
// quasi_cyclic_gf2_matrix_vector_multiply
// GF(2) product of a quasi-cyclic matrix with a lifted vector, one matrix
// entry per command, with vector and accumulator block stores.
// ----------------------------------------------------------------------------
//   channel   ports                                         transfer when
//   input     start, busy, in_action .. in_block_data       start && !busy
//   result    out_valid, out_block_value, out_row_stopped    out_valid
//   config    psel, penable, pwrite, paddr, pwdata, prdata   psel && penable && pwrite
//
// A command is taken by the front, which reduces the shift modulo Z one byte
// a cycle and pushes the command once the queue has room; it takes the next
// command in the cycle that it pushes the last. The back executes one queued
// command at a time, at a pace set by the registered read of the block stores.
// Reset clears the control state only; the block stores hold nothing defined
// until written. The result strobe lasts one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module quasi_cyclic_gf2_matrix_vector_multiply
  import qcmv_pkg::*;
#(
  parameter int MAX_Z    = 64,
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_action,
  input  wire logic [ROW_W-1:0]   in_row_index,
  input  wire logic [COL_W-1:0]   in_column_index,
  input  wire logic [SHIFT_W-1:0] in_shift_amount,
  input  wire logic [BLK_W-1:0]   in_block_data,
  output logic                    out_valid,
  output logic [BLK_W-1:0]        out_block_value,
  output logic                    out_row_stopped,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int ZCAP = (MAX_Z < BLK_W) ? MAX_Z : BLK_W;

  logic [Z_W-1:0]  lifting_r;
  logic [CU_W-1:0] columns_r;
  logic [Z_W-1:0]  z_eff;
  logic            cfg_write;
  cfg_t            cfg;
  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_empty;
  entry_t          q_entry;
  entry_t          q_head;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lifting_r <= Z_W'(64);
      columns_r <= CU_W'(128);
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_LIFTING: lifting_r <= pwdata[Z_W-1:0];
        REG_COLUMNS: columns_r <= pwdata[CU_W-1:0];
        default:     lifting_r <= lifting_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_LIFTING: prdata = {{(32-Z_W){1'b0}}, lifting_r};
      REG_COLUMNS: prdata = {{(32-CU_W){1'b0}}, columns_r};
      default:     prdata = '0;
    endcase
  end

  // Zero means a one-bit block; larger sizes saturate at ZCAP, the smaller of MAX_Z and the widest block.
  always_comb begin
    priority if (lifting_r == '0) begin
      z_eff = Z_W'(1);
    end else if ({1'b0, lifting_r} > 8'(ZCAP)) begin
      z_eff = Z_W'(ZCAP);
    end else begin
      z_eff = lifting_r;
    end
  end

  always_comb begin
    cfg.z    = z_eff;
    cfg.cols = columns_r;
    if (z_eff >= Z_W'(BLK_W)) begin
      cfg.mask = '1;
    end else begin
      cfg.mask = (BLK_W'(1) << z_eff) - BLK_W'(1);
    end
  end

  qcmv_front #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_row_index    (in_row_index),
    .in_column_index (in_column_index),
    .in_shift_amount (in_shift_amount),
    .in_block_data   (in_block_data),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_entry         (q_entry)
  );

  qcmv_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty)
  );

  qcmv_back #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .q_head          (q_head),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_block_value (out_block_value),
    .out_row_stopped (out_row_stopped)
  );

endmodule

`default_nettype wire

// ===== dv/qcmv_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcmv_checker
// Watches the command, result and register channels of the quasi-cyclic
// GF(2) matrix-vector unit. It keeps its own copy of the block stores and the
// row state, works out the result of every accepted command and compares the
// results in order as they arrive.
// ----------------------------------------------------------------------------
module qcmv_checker
  import qcmv_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire logic [1:0]         in_action,
  input  wire logic [ROW_W-1:0]   in_row_index,
  input  wire logic [COL_W-1:0]   in_column_index,
  input  wire logic [SHIFT_W-1:0] in_shift_amount,
  input  wire logic [BLK_W-1:0]   in_block_data,
  input  wire logic               out_valid,
  input  wire logic [BLK_W-1:0]   out_block_value,
  input  wire logic               out_row_stopped,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  input  wire logic [31:0]        prdata,
  input  wire logic               pready,
  output int                      fail_count,
  output int                      pending,
  output int                      results_checked,
  output int                      stops_seen
);

  localparam int STORE_COLS = 128;
  localparam int STORE_ROWS = 64;
  localparam int Z_CAP      = 64;

  typedef struct packed {
    logic [BLK_W-1:0] value;
    logic             stopped;
  } block_result_t;

  logic [BLK_W-1:0] vec_blocks [STORE_COLS];
  logic [BLK_W-1:0] acc_rows [STORE_ROWS];
  logic             row_halted;
  logic [ROW_W-1:0] active_row;
  logic [Z_W-1:0]   z_reg;
  logic [CU_W-1:0]  cols_reg;
  block_result_t    expected_q [$];

  task automatic report(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t ns  mismatch: %s", $time, msg);
  endtask

  // Zero lifting size behaves as one; anything above the widest block saturates.
  function automatic int unsigned lifting();
    int unsigned z;
    z = z_reg;
    if (z == 0) z = 1;
    if (z > Z_CAP) z = Z_CAP;
    return z;
  endfunction

  function automatic logic [BLK_W-1:0] lift_mask(int unsigned z);
    return (z >= BLK_W) ? '1 : (64'd1 << z) - 64'd1;
  endfunction

  // Output bit d takes input bit (d + s) mod z.
  function automatic logic [BLK_W-1:0] circulant(logic [BLK_W-1:0] v, int unsigned z,
                                                 int unsigned s);
    logic [BLK_W-1:0] r;
    r = '0;
    v = v & lift_mask(z);
    for (int unsigned d = 0; d < BLK_W; d++) begin
      if (d < z) r[d] = v[(d + s) % z];
    end
    return r;
  endfunction

  function automatic block_result_t execute_entry(action_t act, logic [ROW_W-1:0] row,
                                                  logic [COL_W-1:0] col,
                                                  logic [SHIFT_W-1:0] shift,
                                                  logic [BLK_W-1:0] data);
    block_result_t    res;
    int unsigned      z;
    int unsigned      limit;
    int unsigned      sh;
    logic [BLK_W-1:0] m;
    res   = '0;
    z     = lifting();
    m     = lift_mask(z);
    sh    = shift;
    limit = (cols_reg > STORE_COLS) ? STORE_COLS : cols_reg;
    case (act)
      ACT_LOAD_X: begin
        if (col < STORE_COLS) begin
          vec_blocks[col] = data & m;
          res.value = vec_blocks[col];
        end
      end
      ACT_LOAD_B: begin
        acc_rows[row] = data & m;
        res.value = acc_rows[row];
      end
      ACT_APPLY: begin
        if (row != active_row) begin
          active_row = row;
          row_halted = 1'b0;
        end
        if (row_halted) begin
          res.value   = acc_rows[row];
          res.stopped = 1'b1;
        end else if (col >= limit) begin
          row_halted  = 1'b1;
          res.value   = acc_rows[row];
          res.stopped = 1'b1;
        end else begin
          acc_rows[row] = (acc_rows[row] ^ circulant(vec_blocks[col], z, sh % z)) & m;
          res.value = acc_rows[row];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    block_result_t want;
    block_result_t got;
    logic [31:0]   reg_val;
    if (!rst_n) begin
      row_halted = 1'b0;
      active_row = '0;
      z_reg      = 7'd64;
      cols_reg   = 8'd128;
      expected_q.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_LIFTING) z_reg = pwdata[Z_W-1:0];
          else cols_reg = pwdata[CU_W-1:0];
        end else begin
          reg_val = (paddr[2] == REG_LIFTING) ? 32'(z_reg) : 32'(cols_reg);
          if (prdata !== reg_val)
            report($sformatf("register read at %0d: expected %h, got %h",
                             paddr, reg_val, prdata));
        end
      end
      if (out_valid) begin
        got.value   = out_block_value;
        got.stopped = out_row_stopped;
        results_checked++;
        if (got.stopped === 1'b1) stops_seen++;
        if (expected_q.size() == 0) begin
          report($sformatf("result %h/%b with nothing outstanding",
                           got.value, got.stopped));
        end else begin
          want = expected_q.pop_front();
          if (got.value !== want.value || got.stopped !== want.stopped)
            report($sformatf("value expected %h, got %h; stopped expected %b, got %b",
                             want.value, got.value, want.stopped, got.stopped));
        end
      end
      if (start && !busy)
        expected_q.push_back(execute_entry(action_t'(in_action), in_row_index,
                                           in_column_index, in_shift_amount,
                                           in_block_data));
    end
    pending <= expected_q.size();
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives commands and register writes into the quasi-cyclic GF(2)
// matrix-vector unit: a directed opening on the corner cases, then random
// row runs of matrix entries under several register settings and idle
// patterns. The checker beside the block predicts and compares the results.
// ----------------------------------------------------------------------------
module testbench;
  import qcmv_pkg::*;

  localparam logic [2:0] ADDR_LIFTING = 3'd0;
  localparam logic [2:0] ADDR_COLUMNS = 3'd4;
  localparam int         COL_SLOTS    = 128;
  localparam int         ROW_SLOTS    = 64;
  localparam int         PHASE_ITEMS  = 115;

  logic               clk             = 1'b0;
  logic               rst_n           = 1'b0;
  logic               start           = 1'b0;
  logic               busy;
  logic [1:0]         in_action       = '0;
  logic [ROW_W-1:0]   in_row_index    = '0;
  logic [COL_W-1:0]   in_column_index = '0;
  logic [SHIFT_W-1:0] in_shift_amount = '0;
  logic [BLK_W-1:0]   in_block_data   = '0;
  logic               out_valid;
  logic [BLK_W-1:0]   out_block_value;
  logic               out_row_stopped;
  logic               psel            = 1'b0;
  logic               penable         = 1'b0;
  logic               pwrite          = 1'b0;
  logic [2:0]         paddr           = '0;
  logic [31:0]        pwdata          = '0;
  logic [31:0]        prdata;
  logic               pready;

  int fail_count;
  int pending;
  int results_checked;
  int stops_seen;

  // Which store entries hold a defined value; nothing unwritten is ever read.
  bit               x_loaded [COL_SLOTS];
  bit               b_loaded [ROW_SLOTS];
  int unsigned      z_now    = 64;
  int unsigned      cols_now = 128;
  int unsigned      idle_pct = 0;
  int               sent     = 0;
  int               settings = 1;
  logic [ROW_W-1:0] run_row  = '0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  quasi_cyclic_gf2_matrix_vector_multiply u_top (
    .clk, .rst_n, .start, .busy,
    .in_action, .in_row_index, .in_column_index, .in_shift_amount, .in_block_data,
    .out_valid, .out_block_value, .out_row_stopped,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  qcmv_checker u_checker (
    .clk, .rst_n, .start, .busy,
    .in_action, .in_row_index, .in_column_index, .in_shift_amount, .in_block_data,
    .out_valid, .out_block_value, .out_row_stopped,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .fail_count, .pending, .results_checked, .stops_seen
  );

  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send(action_t act, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                      logic [SHIFT_W-1:0] shift, logic [BLK_W-1:0] data);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start           <= 1'b1;
    in_action       <= act;
    in_row_index    <= row;
    in_column_index <= col;
    in_shift_amount <= shift;
    in_block_data   <= data;
    do @(posedge clk); while (busy !== 1'b0);
    if (act == ACT_LOAD_X && col < COL_SLOTS) x_loaded[col] = 1'b1;
    if (act == ACT_LOAD_B) b_loaded[row] = 1'b1;
    sent++;
  endtask

  // Called at the edge of the last transfer; pending is a registered copy of the checker's count.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic cfg_access(bit wr, logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Upper bits of the write data are noise that the register must drop.
  task automatic configure(int unsigned z, int unsigned cols);
    settle();
    cfg_access(1'b1, ADDR_LIFTING,
               {25'($urandom_range(0, 32'h1FF_FFFF)), z[Z_W-1:0]});
    cfg_access(1'b0, ADDR_LIFTING, '0);
    cfg_access(1'b1, ADDR_COLUMNS,
               {24'($urandom_range(0, 32'hFF_FFFF)), cols[CU_W-1:0]});
    cfg_access(1'b0, ADDR_COLUMNS, '0);
    z_now    = z & 32'h7F;
    cols_now = cols & 32'hFF;
    settings++;
  endtask

  function automatic logic [BLK_W-1:0] rand_block();
    case ($urandom_range(9))
      0:       return '1;
      1:       return '0;
      2:       return 64'd1 << $urandom_range(63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [SHIFT_W-1:0] rand_shift();
    int unsigned z;
    z = (z_now == 0) ? 1 : (z_now > 64 ? 64 : z_now);
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return SHIFT_W'(z * $urandom_range(0, 65535 / z));
      3, 4, 5: return SHIFT_W'($urandom_range(z - 1));
      default: return SHIFT_W'($urandom);
    endcase
  endfunction

  // Mostly runs of matrix entries along one row, with loads and noise between.
  task automatic random_item();
    int unsigned      limit;
    int unsigned      pick;
    logic [COL_W-1:0] col;
    limit = (cols_now > COL_SLOTS) ? COL_SLOTS : cols_now;
    pick  = $urandom_range(99);
    if (pick < 12) begin
      send(ACT_LOAD_X, ROW_W'($urandom), COL_W'($urandom), SHIFT_W'($urandom),
           rand_block());
    end else if (pick < 20) begin
      send(ACT_LOAD_B, ROW_W'($urandom), COL_W'($urandom), SHIFT_W'($urandom),
           rand_block());
    end else if (pick < 24) begin
      send(ACT_NONE, ROW_W'($urandom), COL_W'($urandom), SHIFT_W'($urandom),
           rand_block());
    end else begin
      if ($urandom_range(99) < 25) run_row = ROW_W'($urandom);
      if (!b_loaded[run_row]) begin
        send(ACT_LOAD_B, run_row, COL_W'($urandom), SHIFT_W'($urandom), rand_block());
      end
      if (limit > 0 && $urandom_range(99) < 90) begin
        col = COL_W'($urandom_range(limit - 1));
        if (!x_loaded[col]) begin
          send(ACT_LOAD_X, ROW_W'($urandom), col, SHIFT_W'($urandom), rand_block());
        end
      end else begin
        col = COL_W'($urandom_range(255, limit));
      end
      send(ACT_APPLY, run_row, col, rand_shift(), rand_block());
    end
  endtask

  initial begin
    int unsigned z_set    [8] = '{64, 8, 1, 37, 127, 16, 63, 0};
    int unsigned cols_set [8] = '{128, 16, 3, 100, 255, 1, 127, 0};
    int unsigned idle_set [8] = '{0, 64, 17, 0, 64, 17, 0, 64};
    z_set[7]    = $urandom_range(1, 64);
    cols_set[7] = $urandom_range(1, 128);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening under the reset settings.
    send(ACT_LOAD_X, 0, 0, 0, '1);
    send(ACT_LOAD_X, 0, 127, 0, 64'hAAAA_AAAA_AAAA_AAAA);
    send(ACT_LOAD_X, 0, 1, 0, 64'h1);
    send(ACT_LOAD_X, 0, 200, 0, 64'h0123_4567_89AB_CDEF);
    send(ACT_LOAD_B, 0, 0, 0, '0);
    send(ACT_LOAD_B, 63, 0, 0, '1);
    send(ACT_APPLY, 0, 1, 0, '0);
    send(ACT_APPLY, 0, 1, 1, '0);
    send(ACT_APPLY, 0, 1, 16'hFFFF, '0);
    send(ACT_APPLY, 0, 0, 16'd64, '0);
    send(ACT_APPLY, 0, 128, 0, '0);
    send(ACT_APPLY, 0, 1, 3, '0);
    send(ACT_APPLY, 63, 127, 5, '0);
    send(ACT_APPLY, 0, 1, 2, '0);
    send(ACT_NONE, 6'h3F, 8'hFF, 16'hFFFF, '1);
    send(ACT_APPLY, 0, 8'hFF, 0, '0);
    // A narrower block leaves the upper stored bits out of the rotation.
    configure(5, 2);
    send(ACT_APPLY, 63, 0, 3, '0);
    send(ACT_LOAD_X, 0, 2, 0, '1);
    send(ACT_APPLY, 63, 2, 0, '0);
    send(ACT_LOAD_B, 5, 0, 0, '1);
    // Zero registers: every entry ends its row at once.
    configure(0, 0);
    send(ACT_APPLY, 5, 0, 7, '0);
    send(ACT_LOAD_X, 0, 3, 0, '1);
    configure(127, 255);
    send(ACT_APPLY, 63, 127, 16'h1234, '0);
    send(ACT_APPLY, 63, 0, 16'd100, '0);

    for (int p = 0; p < 8; p++) begin
      configure(z_set[p], cols_set[p]);
      idle_pct = idle_set[p];
      repeat (PHASE_ITEMS) random_item();
    end

    settle();
    repeat (10) @(posedge clk);
    $display("Run covered %0d commands under %0d register settings.", sent, settings);
    $display("%0d results checked, %0d of them with the row stopped.",
             results_checked, stops_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/qcmv_pkg.sv
hdl/qcmv_ram.sv
hdl/qcmv_queue.sv
hdl/qcmv_front.sv
hdl/qcmv_back.sv
hdl/quasi_cyclic_gf2_matrix_vector_multiply.sv
dv/qcmv_checker.sv
dv/testbench.sv
